>>> hdl/snfa_pkg.sv
// ----------------------------------------------------------------------------
// snfa_pkg
// Shared types, constants and saturation helpers of the spring network
// force accumulator.
// ----------------------------------------------------------------------------
package snfa_pkg;

   localparam int DataW    = 32;
   localparam int RadW     = 31;
   localparam int AccW     = 48;
   localparam int MulW     = 33;
   localparam int ProdW    = 66;
   localparam int WideW    = 64;
   localparam int QuotW    = 31;
   localparam int IterW    = 5;
   localparam int AddrW    = 3;
   localparam int ReqDataW = 224;
   localparam int RspDataW = 160;

   localparam logic [IterW-1:0] RootLastIter = 5'd31;
   localparam logic [IterW-1:0] DivLastIter  = 5'd30;

   localparam logic [DataW-1:0] SpringReset = 32'd524288;
   localparam logic [DataW-1:0] DampReset   = 32'd655360;

   // register index as decoded from paddr[2]
   localparam logic RegSpring = 1'b0;
   localparam logic RegDamp   = 1'b1;

   localparam logic signed [ProdW-1:0] S32MaxW = 66'sd2147483647;
   localparam logic signed [ProdW-1:0] S32MinW = -66'sd2147483648;
   localparam logic signed [AccW:0]    S48Max  = 49'sd140737488355327;
   localparam logic signed [AccW:0]    S48Min  = -49'sd140737488355328;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_SQX,
      OP_SQY,
      OP_ROOT,
      OP_LEN,
      OP_KMUL,
      OP_PRODX,
      OP_PRODY,
      OP_DIVINIT,
      OP_DIV,
      OP_ACC,
      OP_DAMPX,
      OP_DAMPY,
      OP_EMIT
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic len_zero;
   } status_type;

   function automatic logic signed [DataW-1:0] sat32(input logic signed [ProdW-1:0] v);
      logic signed [DataW-1:0] r;
      if (v > S32MaxW) begin
         r = 32'sh7FFFFFFF;
      end else if (v < S32MinW) begin
         r = 32'sh80000000;
      end else begin
         r = v[DataW-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [AccW-1:0] sat48(input logic signed [AccW:0] v);
      logic signed [AccW-1:0] r;
      if (v > S48Max) begin
         r = S48Max[AccW-1:0];
      end else if (v < S48Min) begin
         r = S48Min[AccW-1:0];
      end else begin
         r = v[AccW-1:0];
      end
      return r;
   endfunction

endpackage

>>> hdl/spring_network_force_accumulator_unit.sv
// ----------------------------------------------------------------------------
// spring_network_force_accumulator_unit
// Per-particle spring force accumulator with APB-style register port.
// ----------------------------------------------------------------------------
// One link beat is taken at a time. A present link counted within MAX_LINKS
// passes through a 32-step square root and a 31-step division, both one bit
// per cycle, plus steps through one shared 33x33 multiplier. A present link
// of zero length skips the direction products and the division. A skipped
// link is only loaded and leaves the block idle. The last link of a particle
// adds two damping products and the output load, and the load waits while an
// earlier result still waits in the output register; the result then sits in
// that register while the next link is already taken in.
module spring_network_force_accumulator_unit #(
   parameter int FRAC_BITS = 16,
   parameter int MAX_LINKS = 6
) (
   input  logic                                clock,
   input  logic                                reset,
   // sep_x[31:0], sep_y[63:32], radius_sum_x[94:64], radius_sum_y[125:95],
   // rest_length[157:126], vel_x[189:158], vel_y[221:190], zero pad
   input  logic [snfa_pkg::ReqDataW-1:0]       req_tdata,
   // link_present
   input  logic                                req_tuser,
   input  logic                                req_tlast,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // dpos_x[31:0], accel_x[63:32], dpos_y[95:64], accel_y[127:96],
   // pressure_sum[159:128]
   output logic [snfa_pkg::RspDataW-1:0]       rsp_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [snfa_pkg::AddrW-1:0]          csr_paddr,
   input  logic [snfa_pkg::DataW-1:0]          csr_pwdata,
   output logic [snfa_pkg::DataW-1:0]          csr_prdata,
   output logic                                csr_pready
);

   logic [snfa_pkg::DataW-1:0] spring_ff, damp_ff;
   logic                       csr_write;
   snfa_pkg::cmd_type          cmd;
   snfa_pkg::status_type       status;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == snfa_pkg::RegDamp) ? damp_ff : spring_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         spring_ff <= snfa_pkg::SpringReset;
         damp_ff   <= snfa_pkg::DampReset;
      end else if (csr_write) begin
         if (csr_paddr[2] == snfa_pkg::RegSpring) begin
            spring_ff <= csr_pwdata;
         end else begin
            damp_ff <= csr_pwdata;
         end
      end
   end

   snfa_ctrl #(
      .MAX_LINKS (MAX_LINKS)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_link_present (req_tuser),
      .req_last_link    (req_tlast),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .cmd              (cmd),
      .status           (status)
   );

   snfa_datapath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .spring_constant (spring_ff),
      .damping         (damp_ff),
      .sep_x           (req_tdata[31:0]),
      .sep_y           (req_tdata[63:32]),
      .radius_sum_x    (req_tdata[94:64]),
      .radius_sum_y    (req_tdata[125:95]),
      .rest_length     (req_tdata[157:126]),
      .vel_x           (req_tdata[189:158]),
      .vel_y           (req_tdata[221:190]),
      .rsp_data        (rsp_tdata)
   );

endmodule

>>> hdl/snfa_ctrl.sv
// ----------------------------------------------------------------------------
// snfa_ctrl
// Sequencer of the accumulator: handshakes, link counter, iteration counter
// and the command stream for the datapath.
// ----------------------------------------------------------------------------
module snfa_ctrl #(
   parameter int MAX_LINKS = 6
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic                 req_link_present,
   input  logic                 req_last_link,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output snfa_pkg::cmd_type    cmd,
   input  snfa_pkg::status_type status
);

   localparam int CntW = $clog2(MAX_LINKS + 1);

   typedef enum logic [13:0] {
      ST_IDLE    = 14'b00000000000001,
      ST_SQX     = 14'b00000000000010,
      ST_SQY     = 14'b00000000000100,
      ST_ROOT    = 14'b00000000001000,
      ST_LEN     = 14'b00000000010000,
      ST_KMUL    = 14'b00000000100000,
      ST_PRODX   = 14'b00000001000000,
      ST_PRODY   = 14'b00000010000000,
      ST_DIVINIT = 14'b00000100000000,
      ST_DIV     = 14'b00001000000000,
      ST_ACC     = 14'b00010000000000,
      ST_DAMPX   = 14'b00100000000000,
      ST_DAMPY   = 14'b01000000000000,
      ST_EMIT    = 14'b10000000000000
   } state_type;

   state_type                      state_ff, state_in;
   logic [snfa_pkg::IterW-1:0]     iter_ff, iter_in;
   logic [CntW-1:0]                cnt_ff, cnt_in;
   logic                           last_ff, last_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           below_max;

   assign below_max  = cnt_ff < CntW'(MAX_LINKS);
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      iter_in      = iter_ff;
      cnt_in       = cnt_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd.op       = snfa_pkg::OP_NONE;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.op  = snfa_pkg::OP_LOAD;
               last_in = req_last_link;
               if (req_last_link) begin
                  cnt_in = '0;
               end else if (below_max) begin
                  cnt_in = cnt_ff + 1'b1;
               end
               if (req_link_present && below_max) begin
                  state_in = ST_SQX;
               end else if (req_last_link) begin
                  state_in = ST_DAMPX;
               end
            end
         end
         ST_SQX: begin
            cmd.op   = snfa_pkg::OP_SQX;
            state_in = ST_SQY;
         end
         ST_SQY: begin
            cmd.op   = snfa_pkg::OP_SQY;
            iter_in  = '0;
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            cmd.op  = snfa_pkg::OP_ROOT;
            iter_in = iter_ff + 1'b1;
            if (iter_ff == snfa_pkg::RootLastIter) begin
               state_in = ST_LEN;
            end
         end
         ST_LEN: begin
            cmd.op   = snfa_pkg::OP_LEN;
            state_in = ST_KMUL;
         end
         ST_KMUL: begin
            cmd.op   = snfa_pkg::OP_KMUL;
            state_in = status.len_zero ? ST_ACC : ST_PRODX;
         end
         ST_PRODX: begin
            cmd.op   = snfa_pkg::OP_PRODX;
            state_in = ST_PRODY;
         end
         ST_PRODY: begin
            cmd.op   = snfa_pkg::OP_PRODY;
            state_in = ST_DIVINIT;
         end
         ST_DIVINIT: begin
            cmd.op   = snfa_pkg::OP_DIVINIT;
            iter_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.op  = snfa_pkg::OP_DIV;
            iter_in = iter_ff + 1'b1;
            if (iter_ff == snfa_pkg::DivLastIter) begin
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            cmd.op   = snfa_pkg::OP_ACC;
            state_in = last_ff ? ST_DAMPX : ST_IDLE;
         end
         ST_DAMPX: begin
            cmd.op   = snfa_pkg::OP_DAMPX;
            state_in = ST_DAMPY;
         end
         ST_DAMPY: begin
            cmd.op   = snfa_pkg::OP_DAMPY;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.op       = snfa_pkg::OP_EMIT;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         iter_ff      <= '0;
         cnt_ff       <= '0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         iter_ff      <= iter_in;
         cnt_ff       <= cnt_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> hdl/snfa_datapath.sv
// ----------------------------------------------------------------------------
// snfa_datapath
// Gap, square root, spring force, direction division, accumulators and the
// output register, stepped by the controller's commands.
// ----------------------------------------------------------------------------
module snfa_datapath #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  snfa_pkg::cmd_type                     cmd,
   output snfa_pkg::status_type                  status,
   input  logic [snfa_pkg::DataW-1:0]            spring_constant,
   input  logic [snfa_pkg::DataW-1:0]            damping,
   input  logic signed [snfa_pkg::DataW-1:0]     sep_x,
   input  logic signed [snfa_pkg::DataW-1:0]     sep_y,
   input  logic [snfa_pkg::RadW-1:0]             radius_sum_x,
   input  logic [snfa_pkg::RadW-1:0]             radius_sum_y,
   input  logic signed [snfa_pkg::DataW-1:0]     rest_length,
   input  logic signed [snfa_pkg::DataW-1:0]     vel_x,
   input  logic signed [snfa_pkg::DataW-1:0]     vel_y,
   output logic [snfa_pkg::RspDataW-1:0]         rsp_data
);

   localparam int DW = snfa_pkg::DataW;
   localparam int WW = snfa_pkg::WideW;
   localparam int AW = snfa_pkg::AccW;
   localparam int QW = snfa_pkg::QuotW;

   logic signed [DW-1:0]  gx_ff, gy_ff, rest_ff, vx_ff, vy_ff;
   logic [WW-1:0]         sqx_ff, x_ff, res_ff, bit_ff;
   logic [DW-1:0]         len_ff;
   logic signed [DW-1:0]  elong_ff, force_ff, dx_ff, dy_ff;
   logic signed [WW-1:0]  prod_ff [2];
   logic [DW-1:0]         rem_ff  [2];
   logic [QW-1:0]         low_ff  [2];
   logic [QW-1:0]         quo_ff  [2];
   logic                  sat_ff  [2];
   logic                  neg_ff  [2];
   logic signed [AW-1:0]  fx_acc_ff, fy_acc_ff, pr_acc_ff;
   logic [snfa_pkg::RspDataW-1:0] rsp_data_ff;

   logic signed [DW-1:0]          gx_c, gy_c;
   logic signed [snfa_pkg::MulW-1:0]  mul_a, mul_b;
   logic signed [snfa_pkg::ProdW-1:0] mul_p;
   logic [WW-1:0]                 root_sum;
   logic [DW-1:0]                 len_c;
   logic signed [DW-1:0]          qres [2];
   logic signed [DW-1:0]          acc_x_c, acc_y_c;

   // gap = |sep| - radius sum, saturated to 32 bits
   function automatic logic signed [DW-1:0] gap(input logic signed [DW-1:0] s,
                                                input logic [snfa_pkg::RadW-1:0] r);
      logic signed [DW:0] a;
      logic signed [DW:0] d;
      a = s[DW-1] ? -{s[DW-1], s} : {s[DW-1], s};
      d = a - $signed({2'b00, r});
      return snfa_pkg::sat32(snfa_pkg::ProdW'(d));
   endfunction

   assign gx_c = gap(sep_x, radius_sum_x);
   assign gy_c = gap(sep_y, radius_sum_y);

   // one shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         snfa_pkg::OP_SQX: begin
            mul_a = {gx_ff[DW-1], gx_ff};
            mul_b = {gx_ff[DW-1], gx_ff};
         end
         snfa_pkg::OP_SQY: begin
            mul_a = {gy_ff[DW-1], gy_ff};
            mul_b = {gy_ff[DW-1], gy_ff};
         end
         snfa_pkg::OP_KMUL: begin
            mul_a = {1'b0, spring_constant};
            mul_b = {elong_ff[DW-1], elong_ff};
         end
         snfa_pkg::OP_PRODX: begin
            mul_a = {force_ff[DW-1], force_ff};
            mul_b = {gx_ff[DW-1], gx_ff};
         end
         snfa_pkg::OP_PRODY: begin
            mul_a = {force_ff[DW-1], force_ff};
            mul_b = {gy_ff[DW-1], gy_ff};
         end
         snfa_pkg::OP_DAMPX: begin
            mul_a = {1'b0, damping};
            mul_b = {vx_ff[DW-1], vx_ff};
         end
         snfa_pkg::OP_DAMPY: begin
            mul_a = {1'b0, damping};
            mul_b = {vy_ff[DW-1], vy_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p    = mul_a * mul_b;
   assign root_sum = res_ff + bit_ff;
   assign len_c    = (res_ff > WW'(32'h7FFFFFFF)) ? 32'h7FFFFFFF : res_ff[DW-1:0];
   assign status.len_zero = (len_ff == '0);

   always_comb begin
      for (int i = 0; i < 2; i++) begin
         if (sat_ff[i]) begin
            qres[i] = neg_ff[i] ? 32'sh80000000 : 32'sh7FFFFFFF;
         end else begin
            qres[i] = neg_ff[i] ? -$signed({1'b0, quo_ff[i]}) : $signed({1'b0, quo_ff[i]});
         end
      end
   end

   assign acc_x_c = snfa_pkg::sat32(snfa_pkg::ProdW'(
                       snfa_pkg::sat32(snfa_pkg::ProdW'(fx_acc_ff)))
                       - snfa_pkg::ProdW'(dx_ff));
   assign acc_y_c = snfa_pkg::sat32(snfa_pkg::ProdW'(
                       snfa_pkg::sat32(snfa_pkg::ProdW'(fy_acc_ff)))
                       - snfa_pkg::ProdW'(dy_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         fx_acc_ff <= '0;
         fy_acc_ff <= '0;
         pr_acc_ff <= '0;
      end else begin
         case (cmd.op)
            snfa_pkg::OP_ACC: begin
               pr_acc_ff <= snfa_pkg::sat48((AW+1)'(pr_acc_ff) + (AW+1)'(force_ff));
               if (len_ff != '0) begin
                  fx_acc_ff <= snfa_pkg::sat48((AW+1)'(fx_acc_ff) + (AW+1)'(qres[0]));
                  fy_acc_ff <= snfa_pkg::sat48((AW+1)'(fy_acc_ff) + (AW+1)'(qres[1]));
               end
            end
            snfa_pkg::OP_EMIT: begin
               fx_acc_ff <= '0;
               fy_acc_ff <= '0;
               pr_acc_ff <= '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         snfa_pkg::OP_LOAD: begin
            gx_ff   <= gx_c;
            gy_ff   <= gy_c;
            rest_ff <= rest_length;
            vx_ff   <= vel_x;
            vy_ff   <= vel_y;
         end
         snfa_pkg::OP_SQX: begin
            sqx_ff <= mul_p[WW-1:0];
         end
         snfa_pkg::OP_SQY: begin
            x_ff   <= sqx_ff + mul_p[WW-1:0];
            res_ff <= '0;
            bit_ff <= WW'(1) << (WW - 2);
         end
         snfa_pkg::OP_ROOT: begin
            if (x_ff >= root_sum) begin
               x_ff   <= x_ff - root_sum;
               res_ff <= (res_ff >> 1) + bit_ff;
            end else begin
               res_ff <= res_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
         end
         snfa_pkg::OP_LEN: begin
            len_ff   <= len_c;
            elong_ff <= snfa_pkg::sat32(snfa_pkg::ProdW'($signed({1'b0, len_c}))
                                        - snfa_pkg::ProdW'(rest_ff));
         end
         snfa_pkg::OP_KMUL: begin
            force_ff <= snfa_pkg::sat32(mul_p >>> FRAC_BITS);
         end
         snfa_pkg::OP_PRODX: begin
            prod_ff[0] <= mul_p[WW-1:0];
         end
         snfa_pkg::OP_PRODY: begin
            prod_ff[1] <= mul_p[WW-1:0];
         end
         snfa_pkg::OP_DIVINIT: begin
            for (int i = 0; i < 2; i++) begin
               // magnitude fits 63 bits; quotient of 2^31 or more saturates
               logic [WW-2:0] mag;
               mag = prod_ff[i][WW-1] ? (WW-1)'(-prod_ff[i]) : prod_ff[i][WW-2:0];
               neg_ff[i] <= prod_ff[i][WW-1];
               sat_ff[i] <= mag >= {len_ff, {QW{1'b0}}};
               rem_ff[i] <= mag[WW-2:QW];
               low_ff[i] <= mag[QW-1:0];
               quo_ff[i] <= '0;
            end
         end
         snfa_pkg::OP_DIV: begin
            for (int i = 0; i < 2; i++) begin
               logic [DW-1:0] trial;
               trial = {rem_ff[i][DW-2:0], low_ff[i][QW-1]};
               if (trial >= len_ff) begin
                  rem_ff[i] <= trial - len_ff;
                  quo_ff[i] <= {quo_ff[i][QW-2:0], 1'b1};
               end else begin
                  rem_ff[i] <= trial;
                  quo_ff[i] <= {quo_ff[i][QW-2:0], 1'b0};
               end
               low_ff[i] <= low_ff[i] << 1;
            end
         end
         snfa_pkg::OP_DAMPX: begin
            dx_ff <= snfa_pkg::sat32(mul_p >>> FRAC_BITS);
         end
         snfa_pkg::OP_DAMPY: begin
            dy_ff <= snfa_pkg::sat32(mul_p >>> FRAC_BITS);
         end
         snfa_pkg::OP_EMIT: begin
            rsp_data_ff <= {snfa_pkg::sat32(snfa_pkg::ProdW'(pr_acc_ff)),
                            acc_y_c, vy_ff, acc_x_c, vx_ff};
         end
         default: begin
         end
      endcase
   end

   assign rsp_data = rsp_data_ff;

endmodule

>>> hdl/snfa_checker.sv
// ----------------------------------------------------------------------------
// snfa_checker
// Port-level checks of the accumulator, bound to the top level.
// ----------------------------------------------------------------------------
module snfa_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            req_tlast,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [snfa_pkg::RspDataW-1:0]   rsp_tdata
);

   // a result beat waiting is held as it is
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   // a last link always keeps the block busy for the damping and output steps
   a_busy_after_last: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready)
      else $error("link beat taken while last link in work");

   // a result only appears after the block has been busy
   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result appeared without any work");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("not idle after reset");

endmodule

bind spring_network_force_accumulator_unit snfa_checker u_snfa_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

>>> test/spring_network_force_accumulator_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spring_network_force_accumulator_unit_tb
// Drives neighbour link beats into the accumulator and checks each particle
// result against a cycle-free predictor of the spring, damping and
// saturation arithmetic. It runs several stiffness and damping settings,
// with random gaps on the link side and random stalls on the result side.
// ----------------------------------------------------------------------------
module spring_network_force_accumulator_unit_tb;

   localparam int MaxLinks   = 6;
   localparam int SpringIdx  = 0;
   localparam int DampIdx    = 1;
   localparam int TotalBeats = 1850;
   localparam int Phases     = 6;

   typedef struct {
      logic signed [31:0] sep_x;
      logic signed [31:0] sep_y;
      logic [30:0]        rad_x;
      logic [30:0]        rad_y;
      logic signed [31:0] rest;
      logic               present;
      logic               last;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
   } link_beat_type;

   typedef struct {
      logic [31:0] dpos_x;
      logic [31:0] accel_x;
      logic [31:0] dpos_y;
      logic [31:0] accel_y;
      logic [31:0] pressure;
   } particle_out_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic [snfa_pkg::ReqDataW-1:0] req_tdata = '0;
   logic                          req_tuser = 1'b0;
   logic                          req_tlast = 1'b0;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [snfa_pkg::RspDataW-1:0] rsp_tdata;
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic                          csr_psel = 1'b0;
   logic                          csr_penable = 1'b0;
   logic                          csr_pwrite = 1'b0;
   logic [snfa_pkg::AddrW-1:0]    csr_paddr = '0;
   logic [snfa_pkg::DataW-1:0]    csr_pwdata = '0;
   logic [snfa_pkg::DataW-1:0]    csr_prdata;
   logic                          csr_pready;

   spring_network_force_accumulator_unit dut (
      .clock(clock), .reset(reset),
      .req_tdata(req_tdata), .req_tuser(req_tuser), .req_tlast(req_tlast),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tdata(rsp_tdata), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   logic [31:0]   stiffness = snfa_pkg::SpringReset;
   logic [31:0]   mu = snfa_pkg::DampReset;
   longint        fx_sum = 0;
   longint        fy_sum = 0;
   longint        press_sum = 0;
   int            links_seen = 0;

   link_beat_type    pending_links[$];
   particle_out_type expected_particles[$];
   link_beat_type    cur;
   int            gap_left = 0;
   int            stall_left = 0;
   bit            calm_send = 0;
   bit            calm_recv = 0;
   int            mismatches = 0;
   int            results_seen = 0;
   int            beats_sent = 0;

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint clamp48(longint v);
      if (v > 64'sd140737488355327) return 64'sd140737488355327;
      if (v < -64'sd140737488355328) return -64'sd140737488355328;
      return v;
   endfunction

   function automatic longint unsigned root64(longint unsigned x);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic void accumulate_link(link_beat_type b);
      longint sx, sy, gx, gy, ln, el, f;
      longint unsigned sq, r;
      sx = longint'(b.sep_x);
      sy = longint'(b.sep_y);
      gx = clamp32((sx < 0 ? -sx : sx) - longint'(b.rad_x));
      gy = clamp32((sy < 0 ? -sy : sy) - longint'(b.rad_y));
      sq = longint'(gx * gx) + longint'(gy * gy);
      r = root64(sq);
      ln = (r > 64'd2147483647) ? 64'sd2147483647 : longint'(r);
      el = clamp32(ln - longint'(b.rest));
      f = clamp32((longint'({32'b0, stiffness}) * el) >>> 16);
      press_sum = clamp48(press_sum + f);
      if (ln != 0) begin
         fx_sum = clamp48(fx_sum + clamp32((f * gx) / ln));
         fy_sum = clamp48(fy_sum + clamp32((f * gy) / ln));
      end
   endfunction

   function automatic void predict_particle(link_beat_type b);
      particle_out_type o;
      longint dx, dy;
      if (b.present && links_seen < MaxLinks) accumulate_link(b);
      if (links_seen < MaxLinks) links_seen++;
      if (b.last) begin
         dx = clamp32((longint'({32'b0, mu}) * longint'(b.vel_x)) >>> 16);
         dy = clamp32((longint'({32'b0, mu}) * longint'(b.vel_y)) >>> 16);
         o.dpos_x   = b.vel_x;
         o.dpos_y   = b.vel_y;
         o.accel_x  = 32'(clamp32(clamp32(fx_sum) - dx));
         o.accel_y  = 32'(clamp32(clamp32(fy_sum) - dy));
         o.pressure = 32'(clamp32(press_sum));
         expected_particles.push_back(o);
         fx_sum = 0;
         fy_sum = 0;
         press_sum = 0;
         links_seen = 0;
      end
   endfunction

   // link side
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_particle(cur);
            beats_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               req_tvalid <= 1'b0;
            end else if (pending_links.size() > 0) begin
               cur = pending_links.pop_front();
               req_tdata <= {2'b0, cur.vel_y, cur.vel_x, cur.rest, cur.rad_y,
                             cur.rad_x, cur.sep_y, cur.sep_x};
               req_tuser <= cur.present;
               req_tlast <= cur.last;
               req_tvalid <= 1'b1;
               if ($urandom_range(0, 40) == 0) calm_send = !calm_send;
               gap_left <= calm_send ? 0 : $urandom_range(0, 11);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result side
   always @(posedge clock) begin
      particle_out_type e;
      int d;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (expected_particles.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result beat %h", rsp_tdata);
            end else begin
               e = expected_particles.pop_front();
               if (rsp_tdata != {e.pressure, e.accel_y, e.dpos_y, e.accel_x, e.dpos_x})
               begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"mismatch: exp dpos_x %h accel_x %h dpos_y %h accel_y %h ",
                               "pressure %h, got %h %h %h %h %h"},
                              e.dpos_x, e.accel_x, e.dpos_y, e.accel_y, e.pressure,
                              rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[95:64],
                              rsp_tdata[127:96], rsp_tdata[159:128]);
               end
            end
            if ($urandom_range(0, 30) == 0) calm_recv = !calm_recv;
            d = calm_recv ? 0 : $urandom_range(0, 11);
            stall_left <= (d > 0) ? d - 1 : 0;
            rsp_tready <= (d == 0);
         end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic csr_write(input int idx, input logic [31:0] v);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= snfa_pkg::AddrW'(idx * 4);
      csr_pwdata <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (idx == SpringIdx) stiffness = v;
      else if (idx == DampIdx) mu = v;
   endtask

   task automatic wait_drained();
      while (pending_links.size() != 0 || req_tvalid || expected_particles.size() != 0)
         @(posedge clock);
      // a link without last may still be in flight
      repeat (100) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_signed(int full_odds);
      if ($urandom_range(0, full_odds) == 0) return $urandom;
      return 32'($urandom_range(0, 16 << 16)) - 32'(8 << 16);
   endfunction

   function automatic link_beat_type random_link(bit present, bit last);
      link_beat_type b;
      b.sep_x = pick_signed(7);
      b.sep_y = pick_signed(7);
      b.rad_x = ($urandom_range(0, 7) == 0) ? 31'($urandom) : 31'($urandom_range(0, 4 << 16));
      b.rad_y = ($urandom_range(0, 7) == 0) ? 31'($urandom) : 31'($urandom_range(0, 4 << 16));
      b.rest  = pick_signed(7);
      b.vel_x = pick_signed(3);
      b.vel_y = pick_signed(3);
      if ($urandom_range(0, 15) == 0) begin
         // touching radii: zero length link
         b.sep_x = $urandom_range(0, 1) ? b.rad_x : -b.rad_x;
         b.sep_y = $urandom_range(0, 1) ? b.rad_y : -b.rad_y;
      end
      b.present = present;
      b.last = last;
      return b;
   endfunction

   function automatic link_beat_type fixed_link(logic [31:0] sx, logic [31:0] sy,
                                                logic [30:0] rx, logic [30:0] ry,
                                                logic [31:0] rst, bit p, bit l,
                                                logic [31:0] vx, logic [31:0] vy);
      link_beat_type b;
      b.sep_x = sx; b.sep_y = sy; b.rad_x = rx; b.rad_y = ry; b.rest = rst;
      b.present = p; b.last = l; b.vel_x = vx; b.vel_y = vy;
      return b;
   endfunction

   initial begin
      logic [31:0] k_set[Phases];
      logic [31:0] mu_set[Phases];
      int queued;
      int n;
      k_set  = '{snfa_pkg::SpringReset, 32'h0, 32'hFFFF_FFFF, $urandom, 32'h0001_0000,
                 32'h0000_8000};
      mu_set = '{snfa_pkg::DampReset, 32'h0, 32'hFFFF_FFFF, $urandom, 32'h0000_8000,
                 $urandom};
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      queued = 0;

      // directed corners
      pending_links.push_back(fixed_link(32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h0, 31'h0,
                                         32'h8000_0000, 1, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
      pending_links.push_back(fixed_link(32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF,
                                         31'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 1,
                                         32'h8000_0000, 32'h8000_0000));
      pending_links.push_back(fixed_link(32'h0003_0000, 32'hFFFE_0000, 31'h0003_0000,
                                         31'h0002_0000, 32'h0001_0000, 1, 1,
                                         32'h0001_0000, 32'hFFFF_0000));
      pending_links.push_back(fixed_link(32'h0005_0000, 32'h0, 31'h0, 31'h0, 32'h0, 0, 1,
                                         32'h0, 32'h0));
      for (int i = 0; i < 9; i++)
         pending_links.push_back(fixed_link(32'h0004_0000 + 32'(i << 16), 32'hFFFD_0000,
                                            31'h0001_0000, 31'h0000_8000, 32'h0000_4000,
                                            1, i == 8, 32'h0002_0000, 32'hFFFE_8000));
      pending_links.push_back(fixed_link(32'h7FFF_FFFF, 32'h0, 31'h0, 31'h0, 32'h0, 1, 0,
                                         32'h0, 32'h0));
      pending_links.push_back(fixed_link(32'h0, 32'h8000_0000, 31'h0, 31'h0, 32'h0, 1, 1,
                                         32'h7FFF_FFFF, 32'h8000_0000));
      queued = pending_links.size();
      wait_drained();

      for (int ph = 0; ph < Phases; ph++) begin
         csr_write(SpringIdx, k_set[ph]);
         csr_write(DampIdx, mu_set[ph]);
         while (queued < (TotalBeats * (ph + 1)) / Phases) begin
            if ($urandom_range(0, 9) == 0) begin
               pending_links.push_back(random_link($urandom_range(0, 1), $urandom_range(0, 1)));
               queued++;
            end else begin
               n = $urandom_range(1, 9);
               for (int i = 0; i < n; i++)
                  pending_links.push_back(random_link($urandom_range(0, 4) != 0, i == n - 1));
               queued += n;
            end
         end
         wait_drained();
      end

      $display("covered %0d link beats and %0d particle results over %0d register settings",
               beats_sent, results_seen, Phases + 1);
      $display("mismatches found: %0d", mismatches);
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
